// ----- design/mli_pkg.sv -----
// Shared types, constants and the control program for the modular inverse block.
`timescale 1ns / 1ps
`default_nettype none
package mli_pkg;

   localparam int FIELD_W    = 14;
   localparam int DEF_WIDTH  = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FIELD_W-1:0]      MODULUS_RESET = FIELD_W'(7);
   localparam logic [CSR_ADDR_W-3:0]   REG_MODULUS   = '0;

   // datapath operation of one control step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_BITLEN,
      OP_STEP,
      OP_FIX_SEL,
      OP_FIX_POS,
      OP_DBL_A,
      OP_DBL_B,
      OP_EMIT
   } op_type;

   // branch condition of one control step
   typedef enum logic [2:0] {
      C_ALWAYS,
      C_REQ,
      C_ERR,
      C_BITLEN_DONE,
      C_LOOP_END,
      C_K_ZERO,
      C_OUT_FREE
   } cond_type;

   typedef logic [3:0] upc_type;

   localparam upc_type U_IDLE    = 4'd0;
   localparam upc_type U_CHECK   = 4'd1;
   localparam upc_type U_BITLEN  = 4'd2;
   localparam upc_type U_STEP    = 4'd3;
   localparam upc_type U_FIX_SEL = 4'd4;
   localparam upc_type U_FIX_POS = 4'd5;
   localparam upc_type U_DBL_A   = 4'd6;
   localparam upc_type U_DBL_B   = 4'd7;
   localparam upc_type U_DONE    = 4'd8;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  tgt_t;
      upc_type  tgt_f;
   } uword_type;

   // control store: condition true -> tgt_t, else tgt_f
   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, tgt_t: U_IDLE, tgt_f: U_IDLE};
      unique case (addr)
         U_IDLE:    w = '{op: OP_LOAD,    cond: C_REQ,         tgt_t: U_CHECK,   tgt_f: U_IDLE};
         U_CHECK:   w = '{op: OP_NOP,     cond: C_ERR,         tgt_t: U_DONE,    tgt_f: U_BITLEN};
         U_BITLEN:  w = '{op: OP_BITLEN,  cond: C_BITLEN_DONE, tgt_t: U_STEP,    tgt_f: U_BITLEN};
         U_STEP:    w = '{op: OP_STEP,    cond: C_LOOP_END,    tgt_t: U_FIX_SEL, tgt_f: U_STEP};
         U_FIX_SEL: w = '{op: OP_FIX_SEL, cond: C_ALWAYS,      tgt_t: U_FIX_POS, tgt_f: U_FIX_POS};
         U_FIX_POS: w = '{op: OP_FIX_POS, cond: C_ALWAYS,      tgt_t: U_DBL_A,   tgt_f: U_DBL_A};
         U_DBL_A:   w = '{op: OP_DBL_A,   cond: C_K_ZERO,      tgt_t: U_DONE,    tgt_f: U_DBL_B};
         U_DBL_B:   w = '{op: OP_DBL_B,   cond: C_ALWAYS,      tgt_t: U_DBL_A,   tgt_f: U_DBL_A};
         U_DONE:    w = '{op: OP_EMIT,    cond: C_OUT_FREE,    tgt_t: U_IDLE,    tgt_f: U_DONE};
         default:   w = '{op: OP_NOP,     cond: C_ALWAYS,      tgt_t: U_IDLE,    tgt_f: U_IDLE};
      endcase
      return w;
   endfunction

   // remainder unit
   typedef enum logic [1:0] {
      RM_IDLE,
      RM_CHECK,
      RM_DIV,
      RM_FIN
   } rem_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage
`default_nettype wire

// ----- design/mli_req_if.sv -----
// Request channel: value to invert, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface mli_req_if import mli_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ----- design/mli_rsp_if.sv -----
// Result channel: inverse and range error flag, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface mli_rsp_if import mli_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] inverse;
   logic               range_error;

   modport source (output valid, output inverse, output range_error, input ready);
   modport sink   (input valid, input inverse, input range_error, output ready);
endinterface
`default_nettype wire

// ----- design/mli_rem.sv -----
// Truncating signed remainder unit: a short cut below 2p, else restoring division.
`timescale 1ns / 1ps
`default_nettype none
module mli_rem import mli_pkg::*; #(
   parameter int WIDTH = DEF_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] modulus,
   output logic      [WIDTH-1:0] result,
   output rem_stat_type          stat
);

   localparam int IDX_W = $clog2(WIDTH);

   rem_state_type    st_ff, st_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [WIDTH-1:0] mag_ff, mag_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   trial_sub;
   logic             ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= RM_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      st_in     = st_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      trial     = {rem_ff, mag_ff[WIDTH-1]};
      trial_sub = trial - {1'b0, modulus};
      ge        = trial >= {1'b0, modulus};
      unique case (st_ff)
         RM_IDLE: begin
            if (start) begin
               neg_in = dividend[WIDTH-1];
               mag_in = dividend[WIDTH-1] ? ('0 - dividend) : dividend;
               st_in  = RM_CHECK;
            end
         end
         RM_CHECK: begin
            if ({1'b0, mag_ff} < {modulus, 1'b0}) begin
               rem_in = (mag_ff >= modulus) ? (mag_ff - modulus) : mag_ff;
               st_in  = RM_FIN;
            end else begin
               rem_in = '0;
               cnt_in = IDX_W'(WIDTH - 1);
               st_in  = RM_DIV;
            end
         end
         RM_DIV: begin
            rem_in = ge ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
            mag_in = mag_ff << 1;
            if (cnt_ff == '0) begin
               st_in = RM_FIN;
            end else begin
               cnt_in = cnt_ff - IDX_W'(1);
            end
         end
         RM_FIN: begin
            res_in  = neg_ff ? ('0 - rem_ff) : rem_ff;
            done_in = 1'b1;
            st_in   = RM_IDLE;
         end
         default: st_in = RM_IDLE;
      endcase
   end

   assign result    = res_ff;
   assign stat.busy = (st_ff != RM_IDLE);
   assign stat.done = done_ff;

endmodule
`default_nettype wire

// ----- design/modular_inverse_left_shift.sv -----
// Top level: microcoded left-shift binary modular inverse with APB modulus register.
`timescale 1ns / 1ps
`default_nettype none
// Returns value^-1 mod p for the odd prime p held in the modulus register (byte address 0,
// reset 7). A request with value 0 or above the modulus gives inverse 0 and range_error 1
// after the take, the range check and the post. Otherwise a small control program runs over
// one datapath: the take and the range check, a bit-length scan of max(value, p), then the
// main loop, which waits on the remainder unit for each coefficient reduction that leaves
// -p..p (a short cut below 2p, else its full restoring division), then the sign fix-up
// (select, then make positive), the final modular doublings, and the post of the result.
// The run time is set mainly by the main loop, the doublings and the shared remainder unit.
// One request is worked at a time; the next one is taken as soon as the previous result is
// in the output register, even if that result is still waiting to be taken. Write the
// modulus only while the block is idle.
module modular_inverse_left_shift import mli_pkg::*; #(
   parameter int WIDTH = DEF_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mli_req_if.sink                    req,
   mli_rsp_if.source                  rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int LOOP_CAP = 8 * WIDTH;
   localparam int CNT_W    = $clog2(LOOP_CAP + 1);
   localparam int N_W      = $clog2(WIDTH + 1);
   localparam int IDX_W    = $clog2(WIDTH);

   // ---------------- configuration register ----------------
   logic [FIELD_W-1:0] csr_modulus_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_modulus_ff <= MODULUS_RESET;
      end else if (csr_wr && (paddr[CSR_ADDR_W-1:2] == REG_MODULUS)) begin
         csr_modulus_ff <= pwdata[FIELD_W-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_MODULUS) ? CSR_DATA_W'(csr_modulus_ff) : '0;

   // ---------------- helpers ----------------
   function automatic logic slt(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

   // bit k, positions at or above WIDTH read as the sign
   function automatic logic bit_at(input logic [WIDTH-1:0] x, input logic [N_W-1:0] k);
      if (k >= N_W'(WIDTH)) return x[WIDTH-1];
      return x[k[IDX_W-1:0]];
   endfunction

   // top two bits equal, and not -2^(n-1), the most negative n bit value
   function automatic logic is_small(input logic [WIDTH-1:0] x, input logic [N_W-1:0] n);
      logic hi, nx, lo;
      hi = bit_at(x, n);
      nx = (n == '0) ? 1'b0 : bit_at(x, n - N_W'(1));
      lo = (n == '0) ? 1'b0 : |(x & ~({WIDTH{1'b1}} << (n - N_W'(1))));
      return (!hi && !nx) || (hi && nx && lo);
   endfunction

   function automatic logic at_pw(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] pw);
      logic [WIDTH-1:0] sum;
      sum = x + pw;
      return (x == pw) || (sum == '0);
   endfunction

   function automatic logic [WIDTH-1:0] halve(input logic [WIDTH-1:0] x,
                                              input logic [WIDTH-1:0] p);
      logic [WIDTH-1:0] y;
      y = x[0] ? (x + p) : x;
      return {y[WIDTH-1], y[WIDTH-1:1]};
   endfunction

   // ---------------- sequencer and datapath state ----------------
   upc_type            upc_ff, upc_in;
   logic [WIDTH-1:0]   u_ff, u_in, v_ff, v_in;
   logic [WIDTH-1:0]   r_ff, r_in, s_ff, s_in;
   logic [WIDTH-1:0]   pu_ff, pu_in, pv_ff, pv_in;
   logic [WIDTH-1:0]   t_ff, t_in;
   logic [CNT_W-1:0]   cu_ff, cu_in, cv_ff, cv_in, iter_ff, iter_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic               err_ff, err_in;
   logic               side_ff, side_in;      // reduction lands in s when set, else r
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_inverse_ff, rsp_inverse_in;
   logic               rsp_error_ff, rsp_error_in;

   uword_type          uw;
   logic               cond_true;
   logic               accept;
   logic               out_free;
   logic [WIDTH-1:0]   p_w, a_w, neg_p;
   logic               at_u, at_v, loop_end, rem_idle;
   logic               small_u, small_v, sub, to_u, need_red;
   logic [WIDTH-1:0]   wsum, csum;
   logic [WIDTH-1:0]   fbase, fneg, fres, dbl, dbl_red;
   logic               fsign;

   logic               rem_start;
   logic [WIDTH-1:0]   rem_res;
   rem_stat_type       rem_stat;

   mli_rem #(.WIDTH(WIDTH)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (csum),
      .modulus  (p_w),
      .result   (rem_res),
      .stat     (rem_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= U_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff           <= u_in;
      v_ff           <= v_in;
      r_ff           <= r_in;
      s_ff           <= s_in;
      pu_ff          <= pu_in;
      pv_ff          <= pv_in;
      t_ff           <= t_in;
      cu_ff          <= cu_in;
      cv_ff          <= cv_in;
      iter_ff        <= iter_in;
      n_ff           <= n_in;
      err_ff         <= err_in;
      side_ff        <= side_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign req.ready       = (upc_ff == U_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.inverse     = rsp_inverse_ff;
   assign rsp.range_error = rsp_error_ff;

   assign p_w   = WIDTH'(csr_modulus_ff);
   assign a_w   = WIDTH'(req.value);
   assign neg_p = '0 - p_w;

   always_comb begin
      uw = ucode_rom(upc_ff);

      accept   = req.valid && (upc_ff == U_IDLE);
      out_free = !rsp_valid_ff || rsp.ready;
      rem_idle = !rem_stat.busy && !rem_stat.done;

      // loop exit test: u or v at +-2^shift, or the pass cap
      at_u     = at_pw(u_ff, pu_ff);
      at_v     = at_pw(v_ff, pv_ff);
      loop_end = at_u || at_v || (iter_ff == CNT_W'(LOOP_CAP));

      small_u  = is_small(u_ff, n_ff);
      small_v  = is_small(v_ff, n_ff);
      sub      = (bit_at(u_ff, n_ff) == bit_at(v_ff, n_ff));
      to_u     = (cu_ff <= cv_ff);
      wsum     = to_u ? (sub ? (u_ff - v_ff) : (u_ff + v_ff))
                      : (sub ? (v_ff - u_ff) : (v_ff + u_ff));
      csum     = to_u ? (sub ? (r_ff - s_ff) : (r_ff + s_ff))
                      : (sub ? (s_ff - r_ff) : (s_ff + r_ff));
      need_red = (p_w != '0) && (slt(p_w, csum) || slt(csum, neg_p));

      // sign fix-up
      fbase    = at_v ? s_ff : r_ff;
      fsign    = at_v ? v_ff[WIDTH-1] : u_ff[WIDTH-1];
      fneg     = fbase[WIDTH-1] ? ('0 - fbase) : (p_w - fbase);
      fres     = fsign ? fneg : fbase;

      // first half of a modular doubling
      dbl      = r_ff << 1;
      dbl_red  = slt(dbl, p_w) ? dbl : (dbl - p_w);

      unique case (uw.cond)
         C_ALWAYS:      cond_true = 1'b1;
         C_REQ:         cond_true = accept;
         C_ERR:         cond_true = err_ff;
         C_BITLEN_DONE: cond_true = (t_ff == '0) || t_ff[WIDTH-1];
         C_LOOP_END:    cond_true = rem_idle && loop_end;
         C_K_ZERO:      cond_true = (cv_ff == '0);
         C_OUT_FREE:    cond_true = out_free;
         default:       cond_true = 1'b0;
      endcase
      upc_in = cond_true ? uw.tgt_t : uw.tgt_f;

      u_in           = u_ff;
      v_in           = v_ff;
      r_in           = r_ff;
      s_in           = s_ff;
      pu_in          = pu_ff;
      pv_in          = pv_ff;
      t_in           = t_ff;
      cu_in          = cu_ff;
      cv_in          = cv_ff;
      iter_in        = iter_ff;
      n_in           = n_ff;
      err_in         = err_ff;
      side_in        = side_ff;
      rem_start      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_inverse_in = rsp_inverse_ff;
      rsp_error_in   = rsp_error_ff;

      unique case (uw.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            if (accept) begin
               err_in  = (req.value == '0) || (req.value > csr_modulus_ff);
               u_in    = p_w;
               v_in    = a_w;
               r_in    = '0;
               s_in    = WIDTH'(1);
               pu_in   = WIDTH'(1);
               pv_in   = WIDTH'(1);
               cu_in   = '0;
               cv_in   = '0;
               iter_in = '0;
               n_in    = '0;
               t_in    = slt(a_w, p_w) ? p_w : a_w;
            end
         end
         OP_BITLEN: begin
            if (t_ff[WIDTH-1]) begin
               n_in = N_W'(WIDTH);
            end else if (t_ff != '0) begin
               t_in = t_ff >> 1;
               n_in = n_ff + N_W'(1);
            end
         end
         OP_STEP: begin
            if (rem_stat.done) begin
               if (side_ff) s_in = rem_res;
               else         r_in = rem_res;
            end else if (rem_idle && !loop_end) begin
               iter_in = iter_ff + CNT_W'(1);
               if (small_u) begin
                  u_in  = u_ff << 1;
                  pu_in = pu_ff << 1;
                  cu_in = cu_ff + CNT_W'(1);
                  s_in  = halve(s_ff, p_w);
               end else if (small_v) begin
                  v_in  = v_ff << 1;
                  pv_in = pv_ff << 1;
                  cv_in = cv_ff + CNT_W'(1);
                  r_in  = halve(r_ff, p_w);
               end else begin
                  if (to_u) u_in = wsum;
                  else      v_in = wsum;
                  side_in = !to_u;
                  if (need_red) begin
                     rem_start = 1'b1;
                  end else if (to_u) begin
                     r_in = csum;
                  end else begin
                     s_in = csum;
                  end
               end
            end
         end
         OP_FIX_SEL: begin
            r_in  = fres;
            cv_in = at_v ? cu_ff : cv_ff;
         end
         OP_FIX_POS: begin
            if (r_ff[WIDTH-1]) r_in = r_ff + p_w;
         end
         OP_DBL_A: begin
            if (cv_ff != '0) r_in = dbl_red;
         end
         OP_DBL_B: begin
            if (r_ff[WIDTH-1]) r_in = r_ff + p_w;
            cv_in = cv_ff - CNT_W'(1);
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_inverse_in = FIELD_W'(r_ff);
               rsp_error_in   = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- assertions ----------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.range_error) |-> (rsp.inverse == '0))
      else $error("range error result with nonzero inverse");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second request taken while one is in flight");

   a_rem_start: assert property (@(posedge clock) disable iff (reset)
      rem_start |-> ((upc_ff == U_STEP) && !rem_stat.busy && !rem_stat.done))
      else $error("remainder unit started while busy or outside the main loop");

   a_rem_pulse: assert property (@(posedge clock) disable iff (reset)
      rem_stat.done |=> !rem_stat.done)
      else $error("remainder done held longer than one cycle");

endmodule
`default_nettype wire
